/* hdl/cidr_pkg.sv */
package cidr_pkg;

   // Character codes that steer the parser.
   localparam logic [7:0] CharNul   = 8'd0;
   localparam logic [7:0] CharDot   = 8'd46;
   localparam logic [7:0] CharSlash = 8'd47;
   localparam logic [7:0] CharZero  = 8'd48;

   // Field positions: four octets, then the prefix length, then done.
   localparam logic [2:0] FieldLength = 3'd4;
   localparam logic [2:0] FieldDone   = 3'd5;

   // Character counting within one field.
   localparam logic [2:0] MaxCharCount  = 3'd7;
   localparam logic [2:0] MaxFieldChars = 3'd3;

   // Prefix length limits and the host count of the two longest prefixes.
   localparam logic [5:0] MaxPrefix        = 6'd32;
   localparam logic [5:0] PointToPointLen  = 6'd31;
   localparam logic [5:0] HostCountBase    = 6'd33;

   // First octet class boundaries.
   localparam logic [7:0] ClassBStart = 8'd128;
   localparam logic [7:0] ClassCStart = 8'd192;
   localparam logic [7:0] ClassDStart = 8'd224;
   localparam logic [7:0] ClassEStart = 8'd240;

   // Result word layout.
   localparam int RspDataWidth = 144;

   typedef enum logic [2:0] {
      CLASS_A = 3'd0,
      CLASS_B = 3'd1,
      CLASS_C = 3'd2,
      CLASS_D = 3'd3,
      CLASS_E = 3'd4
   } addr_class_type;

   // One finished string, handed from the parser to the calculator.
   typedef struct packed {
      logic [31:0] address;
      logic [7:0]  length;
      logic        error;
   } cidr_snap_type;

endpackage

/* hdl/cidr_parse.sv */
module cidr_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // char_code [7:0]
   output logic                   snap_valid,
   input  logic                   snap_ready,
   output cidr_pkg::cidr_snap_type snap
);
   import cidr_pkg::*;

   logic [7:0]    acc_ff, acc_in;
   logic [2:0]    index_ff, index_in;
   logic [2:0]    count_ff, count_in;
   logic [7:0]    octet_ff [4];
   logic [7:0]    octet_in [4];
   logic [7:0]    length_ff, length_in;
   logic          error_ff, error_in;
   logic          snap_valid_ff, snap_valid_in;
   cidr_snap_type snap_ff, snap_in;

   logic          accept;
   logic          is_sep;
   logic          is_nul;
   logic [7:0]    folded;
   logic [2:0]    count_next;
   logic [7:0]    close_octet [4];
   logic [7:0]    close_length;
   logic [2:0]    close_index;

   // A new word is taken whenever the snapshot stage is empty or draining.
   assign req_tready = !snap_valid_ff || snap_ready;
   assign accept     = req_tvalid && req_tready;
   assign is_sep     = (req_tdata == CharDot) || (req_tdata == CharSlash);
   assign is_nul     = (req_tdata == CharNul);

   // Decimal fold modulo 256: acc * 10 + (char - 48).
   assign folded = 8'({acc_ff, 3'b000} + {acc_ff, 1'b0}) + (req_tdata - CharZero);
   assign count_next = (count_ff < MaxCharCount) ? count_ff + 3'd1 : count_ff;

   // Stores as they would be after the current field is closed.
   always_comb begin
      close_octet  = octet_ff;
      close_length = length_ff;
      close_index  = index_ff;
      if (index_ff < FieldLength) begin
         close_octet[index_ff[1:0]] = acc_ff;
      end else if (index_ff == FieldLength) begin
         close_length = acc_ff;
      end
      if (index_ff < FieldDone) begin
         close_index = index_ff + 3'd1;
      end
   end

   // Field state update for one accepted character.
   always_comb begin
      acc_in    = acc_ff;
      index_in  = index_ff;
      count_in  = count_ff;
      octet_in  = octet_ff;
      length_in = length_ff;
      error_in  = error_ff;
      snap_in   = snap_ff;
      if (accept) begin
         if (is_sep) begin
            octet_in  = close_octet;
            length_in = close_length;
            index_in  = close_index;
            acc_in    = 8'd0;
            count_in  = 3'd0;
         end else if (!is_nul) begin
            if (index_ff < FieldDone) begin
               acc_in   = folded;
               count_in = count_next;
               if (count_next > MaxFieldChars) begin
                  error_in = 1'b1;
               end
            end
         end else begin
            // End of string: capture the closed fields, then start afresh.
            snap_in.address = {close_octet[0], close_octet[1], close_octet[2], close_octet[3]};
            snap_in.length  = close_length;
            snap_in.error   = error_ff || (index_ff < FieldLength);
            acc_in    = 8'd0;
            index_in  = 3'd0;
            count_in  = 3'd0;
            octet_in  = '{default: 8'd0};
            length_in = 8'd0;
            error_in  = 1'b0;
         end
      end
   end

   // The snapshot stage fills on an end of string and empties when taken.
   always_comb begin
      snap_valid_in = snap_valid_ff;
      if (accept && is_nul) begin
         snap_valid_in = 1'b1;
      end else if (snap_ready) begin
         snap_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= 8'd0;
         index_ff      <= 3'd0;
         count_ff      <= 3'd0;
         octet_ff      <= '{default: 8'd0};
         length_ff     <= 8'd0;
         error_ff      <= 1'b0;
         snap_valid_ff <= 1'b0;
      end else begin
         acc_ff        <= acc_in;
         index_ff      <= index_in;
         count_ff      <= count_in;
         octet_ff      <= octet_in;
         length_ff     <= length_in;
         error_ff      <= error_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   // Snapshot payload needs no reset.
   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

/* hdl/cidr_calc.sv */
module cidr_calc (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    snap_valid,
   output logic                    snap_ready,
   input  cidr_pkg::cidr_snap_type snap,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [cidr_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic                    rsp_tuser
);
   import cidr_pkg::*;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RspDataWidth-1:0] data_ff, data_in;
   logic                    error_ff, error_in;

   logic                    out_free;
   logic                    too_long;
   logic [5:0]              len;
   logic [31:0]             host;
   logic [31:0]             network;
   logic [31:0]             broadcast;
   logic [31:0]             usable;
   logic [7:0]              first_octet;
   addr_class_type          addr_class;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign snap_ready = out_free;

   // Clamp the prefix length and derive the host mask.
   assign too_long  = snap.length > 8'(MaxPrefix);
   assign len       = too_long ? MaxPrefix : snap.length[5:0];
   assign host      = 32'hFFFF_FFFF >> len;
   assign network   = snap.address & ~host;
   assign broadcast = snap.address | host;

   // Usable hosts: host mask minus one, except for the two longest prefixes.
   assign usable = (len < PointToPointLen) ? host - 32'd1
                                           : {26'd0, HostCountBase - len};

   // Class from the leading octet.
   assign first_octet = snap.address[31:24];
   always_comb begin
      if (first_octet < ClassBStart) begin
         addr_class = CLASS_A;
      end else if (first_octet < ClassCStart) begin
         addr_class = CLASS_B;
      end else if (first_octet < ClassDStart) begin
         addr_class = CLASS_C;
      end else if (first_octet < ClassEStart) begin
         addr_class = CLASS_D;
      end else begin
         addr_class = CLASS_E;
      end
   end

   // Result register loads whenever it is free and a snapshot waits.
   always_comb begin
      data_in      = data_ff;
      error_in     = error_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = snap_valid;
         if (snap_valid) begin
            data_in  = {7'd0, usable, addr_class, broadcast, network, len, snap.address};
            error_in = snap.error || too_long;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      error_ff <= error_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = error_ff;

endmodule

/* hdl/ipv4_cidr_text_subnet_calc.sv */
// Path: a terminating NUL word is captured in the parser's snapshot register, then in the
// result register, from which its result can be taken.
// Throughput: one character word per cycle while the snapshot stage is empty or draining;
// parser and result register are separate stages, so input flows while one result waits.
// Reset: synchronous, active high; clears the field state, the stored octets and
// length, the error flag and both valid flags.
module ipv4_cidr_text_subnet_calc (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // char_code [7:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // address [31:0], prefix_length [37:32], network_address [69:38],
   // broadcast_address [101:70], address_class [104:102], usable_hosts [136:105],
   // zero fill [143:137]
   output logic [143:0] rsp_tdata,
   output logic         rsp_tuser     // parse_error [0]
);
   import cidr_pkg::*;

   logic          snap_valid;
   logic          snap_ready;
   cidr_snap_type snap;

   cidr_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   cidr_calc u_calc (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* hdl/cidr_checker.sv */
module cidr_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [143:0] rsp_tdata,
   input logic         rsp_tuser
);

   // A stalled result holds its word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // The prefix length is clamped.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[37:32] <= 6'd32)
      else $error("prefix length above 32");

   // Network and broadcast bracket the address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[69:38] & ~rsp_tdata[31:0]) == 32'd0)
                  && ((rsp_tdata[101:70] | rsp_tdata[31:0]) == rsp_tdata[101:70]))
      else $error("network or broadcast inconsistent with address");

   // The two longest prefixes have fixed host counts.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[37:32] == 6'd31 || rsp_tdata[37:32] == 6'd32)
      |-> rsp_tdata[136:105] == {26'd0, 6'd33 - rsp_tdata[37:32]})
      else $error("host count wrong for a /31 or /32");

endmodule

bind ipv4_cidr_text_subnet_calc cidr_checker u_cidr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
   import cidr_pkg::*;

   typedef logic [7:0] char_queue_type[$];

   // One expected subnet summary, field by field as the result word carries it.
   typedef struct packed {
      logic [31:0]    address;
      logic [5:0]     prefix_length;
      logic [31:0]    network_address;
      logic [31:0]    broadcast_address;
      addr_class_type address_class;
      logic [31:0]    usable_hosts;
      logic           parse_error;
   } subnet_summary_type;

   // Tracks the text parser state, predicts the summary at each NUL and checks
   // the summaries that come out of the block in order.
   class subnet_scoreboard;
      logic [7:0]         field_value;
      logic [2:0]         field_pos;
      logic [2:0]         char_count;
      logic [7:0]         octets[4];
      logic [7:0]         length_field;
      logic               error_flag;
      subnet_summary_type summary_q[$];
      int                 mismatches;

      function new();
         mismatches = 0;
         clear_text();
      endfunction

      function void clear_text();
         field_value  = '0;
         field_pos    = '0;
         char_count   = '0;
         length_field = '0;
         error_flag   = 1'b0;
         foreach (octets[i]) octets[i] = '0;
      endfunction

      // A delimiter or the NUL stores the field in hand and moves on.
      function void end_field();
         if (field_pos < FieldLength)
            octets[field_pos[1:0]] = field_value;
         else if (field_pos == FieldLength)
            length_field = field_value;
         if (field_pos < FieldDone)
            field_pos = field_pos + 3'd1;
         field_value = '0;
         char_count  = '0;
      endfunction

      function void note_char(logic [7:0] code);
         subnet_summary_type summary;
         logic [31:0]        addr;
         logic [31:0]        host_mask;
         logic [32:0]        span;
         int unsigned        plen;
         logic               err;

         if (code == CharDot || code == CharSlash) begin
            end_field();
            return;
         end
         if (code != CharNul) begin
            // Anything else folds like a digit, once all five fields are done it is ignored.
            if (field_pos < FieldDone) begin
               field_value = field_value * 8'd10 + (code - CharZero);
               if (char_count < MaxCharCount)
                  char_count = char_count + 3'd1;
               if (char_count > MaxFieldChars)
                  error_flag = 1'b1;
            end
            return;
         end

         // End of string: close the open field and work out the subnet.
         err = error_flag;
         if (field_pos < FieldLength)
            err = 1'b1;
         if (field_pos < FieldDone)
            end_field();
         addr = {octets[0], octets[1], octets[2], octets[3]};
         plen = length_field;
         if (plen > MaxPrefix) begin
            plen = MaxPrefix;
            err  = 1'b1;
         end
         span      = 33'd1 << (MaxPrefix - plen);
         host_mask = 32'(span - 33'd1);
         summary.address           = addr;
         summary.prefix_length     = 6'(plen);
         summary.network_address   = addr & ~host_mask;
         summary.broadcast_address = addr | host_mask;
         if (octets[0] < ClassBStart)
            summary.address_class = CLASS_A;
         else if (octets[0] < ClassCStart)
            summary.address_class = CLASS_B;
         else if (octets[0] < ClassDStart)
            summary.address_class = CLASS_C;
         else if (octets[0] < ClassEStart)
            summary.address_class = CLASS_D;
         else
            summary.address_class = CLASS_E;
         if (plen < PointToPointLen)
            summary.usable_hosts = 32'(span - 33'd2);
         else
            summary.usable_hosts = HostCountBase - plen;
         summary.parse_error = err;
         summary_q.push_back(summary);
         clear_text();
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch in %s: expected %h, got %h", name, want, got);
         end
      endfunction

      function void check_result(logic [143:0] data, logic err);
         subnet_summary_type want;

         if (summary_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result word %h, error %b", data, err);
            return;
         end
         want = summary_q.pop_front();
         compare_field("address", want.address, data[31:0]);
         compare_field("prefix_length", 32'(want.prefix_length), 32'(data[37:32]));
         compare_field("network_address", want.network_address, data[69:38]);
         compare_field("broadcast_address", want.broadcast_address, data[101:70]);
         compare_field("address_class", 32'(want.address_class), 32'(data[104:102]));
         compare_field("usable_hosts", want.usable_hosts, data[136:105]);
         compare_field("parse_error", 32'(want.parse_error), 32'(err));
      endfunction

      function int pending();
         return summary_q.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;
   logic         rsp_tuser;

   subnet_scoreboard board = new();
   bit               idle_on = 1'b1;
   bit               hold_request = 1'b0;
   int               chars_sent = 0;

   ipv4_cidr_text_subnet_calc u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Give up well past the slowest correct run.
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

   // Offer one character, with an occasional idle burst first, and wait for it to be taken.
   task automatic send_char(input logic [7:0] code);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      do @(posedge clock); while (!req_tready);
      board.note_char(code);
      chars_sent++;
   endtask

   task automatic send_text(input char_queue_type text);
      foreach (text[k]) send_char(text[k]);
   endtask

   task automatic send_string(input string s);
      for (int k = 0; k < s.len(); k++) send_char(s[k]);
      send_char(CharNul);
   endtask

   function automatic void add_decimal(ref char_queue_type q, input int unsigned value,
                                       input int unsigned zeros);
      string digits;
      digits = $sformatf("%0d", value);
      repeat (zeros) q.push_back(CharZero);
      for (int k = 0; k < digits.len(); k++) q.push_back(digits[k]);
   endfunction

   // Mostly well-formed CIDR text with random content; the rest is cut short,
   // carries an over-long field, or is plain noise. Every string ends in NUL.
   function automatic void build_cidr(ref char_queue_type q);
      int unsigned kind, value, zeros, spot;
      q.delete();
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
         repeat ($urandom_range(1, 15)) q.push_back(8'($urandom_range(0, 255)));
         q.push_back(CharNul);
         return;
      end
      spot = (kind == 8) ? $urandom_range(0, 4) : 5;
      for (int i = 0; i < 4; i++) begin
         case ($urandom_range(0, 5))
            0: value = 0;
            1: value = 255;
            default: value = $urandom_range(0, 255);
         endcase
         if (i == spot)
            zeros = $urandom_range(1, 6);
         else
            zeros = (value < 100 && $urandom_range(0, 3) == 0) ? 1 : 0;
         add_decimal(q, value, zeros);
         if (i < 3 && $urandom_range(0, 15) != 0)
            q.push_back(CharDot);
         else
            q.push_back(CharSlash);
      end
      case ($urandom_range(0, 7))
         0: value = 0;
         1: value = 32;
         2: value = $urandom_range(33, 255);
         default: value = $urandom_range(0, 32);
      endcase
      add_decimal(q, value, (spot == 4) ? $urandom_range(1, 6) : 0);
      // Trailing text after the length folds into it until a delimiter closes it, then is ignored.
      if ($urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(1, 255)));
      if (kind == 7)
         repeat ($urandom_range(1, q.size())) void'(q.pop_back());
      q.push_back(CharNul);
   endfunction

   task automatic send_random_strings(input int limit);
      char_queue_type text;
      while (chars_sent < limit) begin
         build_cidr(text);
         send_text(text);
      end
   endtask

   // Result side: check each accepted word, then choose tready for the next cycle.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            board.check_result(rsp_tdata, rsp_tuser);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = 300;
         end
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, zero and over-long prefixes, missing and
      // over-long fields, trailing text, a bare NUL and a non-digit character.
      send_string("255.255.255.255/32");
      send_string("0.0.0.0/0");
      send_string("1.2.3.4/33");
      send_string("1234.5");
      send_string("99.9.8.7/31x./");
      send_string("");
      send_char(8'hFF);
      send_string("/8");

      // Let the block drain completely before going on.
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);

      // Hold the result side off for a long stretch while text keeps coming.
      hold_request = 1'b1;
      send_random_strings(chars_sent + 80);

      send_random_strings(480);

      // Final stretch with no idling on either side.
      idle_on = 1'b0;
      send_random_strings(550);
      req_tvalid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
